>>> rtl/acl_pkg.sv
// Shared types, field layout and codes for the IPv4 allow-rule matcher.
package acl_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned IN_DATA_W = 232;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CONNECT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SEND = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_MATCH = 2'd3;

  localparam int unsigned FLG_SRC_CIDR = 0;
  localparam int unsigned FLG_DST_EXACT = 1;
  localparam int unsigned FLG_PORT_RANGE = 2;
  localparam int unsigned FLG_TCP = 3;
  localparam int unsigned FLG_UDP = 4;
  localparam int unsigned FLG_ICMP = 5;
  localparam int unsigned FLG_PORT_EXACT = 6;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] PROTO_ICMP = 8'd1;

  localparam logic [15:0] PORT_REFUSED = 16'd1;

  typedef struct packed {
    logic [6:0]  flags;
    logic [31:0] network;
    logic [31:0] mask;
    logic [31:0] dest_addr;
    logic [15:0] port_low;
    logic [15:0] port_high;
  } rule_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [6:0]          slot;
    rule_t               rule;
    logic [7:0]          proto;
    logic [31:0]         src;
    logic [31:0]         dst;
    logic [15:0]         port;
  } item_t;

  typedef struct packed {
    logic latch_item;
    logic clear_we;
    logic item_we;
    logic rd_en;
    logic load_out;
    logic hit;
  } acl_cmd_t;

  typedef struct packed {
    logic in_write;
    logic slot_ok;
    logic rvalid;
    logic match;
  } acl_stat_t;

  function automatic logic rule_pass(rule_t r, logic [7:0] proto, logic [31:0] src,
                                     logic [31:0] dst, logic [15:0] port);
    logic ok;
    ok = 1'b1;
    if (proto == PROTO_TCP && !r.flags[FLG_TCP]) ok = 1'b0;
    if (proto == PROTO_UDP && !r.flags[FLG_UDP]) ok = 1'b0;
    if (proto == PROTO_ICMP && !r.flags[FLG_ICMP]) ok = 1'b0;
    if (r.flags[FLG_SRC_CIDR] && ((src & r.mask) != r.network)) ok = 1'b0;
    if (r.flags[FLG_DST_EXACT] && (dst != r.dest_addr)) ok = 1'b0;
    if (proto != PROTO_ICMP) begin
      if (r.flags[FLG_PORT_RANGE]) begin
        if (port < r.port_low || port > r.port_high) ok = 1'b0;
      end else if (r.flags[FLG_PORT_EXACT]) begin
        if (port != r.port_low) ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

>>> rtl/acl_dpath.sv
// Datapath: item register, rule memory, match logic and result register.
module acl_dpath #(
  parameter int unsigned RULE_DEPTH = 128,
  parameter int unsigned AW = 7,
  parameter int unsigned CW = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [acl_pkg::IN_DATA_W-1:0]       in_data_i,
  input  logic [acl_pkg::ACTION_W-1:0]        in_action_i,
  input  acl_pkg::acl_cmd_t                   cmd_i,
  input  logic [CW-1:0]                       idx_i,
  output acl_pkg::acl_stat_t                  stat_o,
  output logic [acl_pkg::OUT_DATA_W-1:0]      out_data_o
);

  acl_pkg::item_t item_q;
  acl_pkg::item_t item_in;
  acl_pkg::rule_t mem_q [RULE_DEPTH];
  acl_pkg::rule_t rdata_q;
  logic           rvalid_q;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic [acl_pkg::OUT_DATA_W-1:0] out_q;
  logic [acl_pkg::OUT_DATA_W-1:0] out_d;
  logic [15:0]    pres;
  logic           repl;
  logic           drop;
  logic           is_tcp_udp;

  always_comb begin
    item_in.action         = in_action_i;
    item_in.slot           = in_data_i[6:0];
    item_in.rule.flags     = in_data_i[13:7];
    item_in.rule.network   = in_data_i[45:14];
    item_in.rule.mask      = in_data_i[77:46];
    item_in.rule.dest_addr = in_data_i[109:78];
    item_in.rule.port_low  = in_data_i[125:110];
    item_in.rule.port_high = in_data_i[141:126];
    item_in.proto          = in_data_i[149:142];
    item_in.src            = in_data_i[181:150];
    item_in.dst            = in_data_i[213:182];
    item_in.port           = in_data_i[229:214];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      item_q <= item_in;
    end
  end

  assign wr_addr = cmd_i.clear_we ? idx_i[AW-1:0] : AW'(item_q.slot);
  assign rd_addr = idx_i[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_we) begin
      mem_q[wr_addr] <= '0;
    end else if (cmd_i.item_we) begin
      mem_q[wr_addr] <= item_q.rule;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= cmd_i.rd_en;
    end
  end

  assign stat_o.in_write = (in_action_i == acl_pkg::ACT_WRITE);
  assign stat_o.slot_ok  = (32'(item_q.slot) < 32'(RULE_DEPTH));
  assign stat_o.rvalid   = rvalid_q;
  assign stat_o.match    = acl_pkg::rule_pass(rdata_q, item_q.proto, item_q.src,
                                              item_q.dst, item_q.port);

  always_comb begin
    is_tcp_udp = (item_q.proto == acl_pkg::PROTO_TCP) ||
                 (item_q.proto == acl_pkg::PROTO_UDP);
    pres = item_q.port;
    repl = 1'b0;
    drop = 1'b0;
    case (item_q.action)
      acl_pkg::ACT_CONNECT: begin
        if (is_tcp_udp && !cmd_i.hit) begin
          pres = acl_pkg::PORT_REFUSED;
          repl = 1'b1;
        end
      end
      acl_pkg::ACT_SEND: begin
        if (item_q.proto == acl_pkg::PROTO_UDP && !cmd_i.hit) begin
          drop = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (item_q.action == acl_pkg::ACT_WRITE) begin
      out_d = '0;
    end else begin
      out_d = {5'd0, drop, repl, pres, cmd_i.hit};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> rtl/acl_ctrl.sv
// Controller: clearing pass, item dispatch, rule scan sequencing and output valid.
module acl_ctrl #(
  parameter int unsigned RULE_DEPTH = 128,
  parameter int unsigned CW = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic [7:0]         active_rules_i,
  input  acl_pkg::acl_stat_t stat_i,
  output acl_pkg::acl_cmd_t  cmd_o,
  output logic [CW-1:0]      idx_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_WRITE  = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  localparam logic [CW-1:0] LAST_IDX = CW'(RULE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(RULE_DEPTH);

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          hit_q, hit_d;
  logic          out_vld_q, out_vld_d;
  logic [CW-1:0] limit;
  logic          accept;

  assign limit = (32'(active_rules_i) >= 32'(RULE_DEPTH)) ? DEPTH_C : CW'(active_rules_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept = in_ready_o && in_valid_i;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    hit_d   = hit_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_we = 1'b1;
        idx_d = idx_q + CW'(1);
        if (idx_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.latch_item = 1'b1;
          idx_d = '0;
          hit_d = 1'b0;
          state_d = stat_i.in_write ? ST_WRITE : ST_SCAN;
        end
      end
      ST_WRITE: begin
        cmd_o.item_we = stat_i.slot_ok;
        state_d = ST_RESULT;
      end
      ST_SCAN: begin
        if (stat_i.rvalid && stat_i.match) begin
          hit_d = 1'b1;
          state_d = ST_RESULT;
        end else if (idx_q < limit) begin
          cmd_o.rd_en = 1'b1;
          idx_d = idx_q + CW'(1);
        end else if (!stat_i.rvalid) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    cmd_o.hit = hit_q;
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      idx_q     <= '0;
      hit_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      hit_q     <= hit_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign idx_o = idx_q;

endmodule

>>> rtl/ipv4_acl_whitelist_match.sv
// Top level of the IPv4 allow-rule matcher with its configuration register.
//
// Items enter on the s_axis channel: tuser carries the action, tdata the rule
// and packet fields. A write action stores one rule into the table; a check
// action scans the first N rules, N being min(active_rules, RULE_DEPTH), one
// rule per cycle through the single read port of the rule memory, and stops
// at the first match. Every item gives one result item on the m_axis channel.
// A write item passes through the WRITE and RESULT states; a check item scans
// up to N rules, fewer when a rule matches early. One item is in work at a
// time, so the next item is taken in the cycle after the result is loaded.
// The result sits in an output register; the next item is accepted while it
// waits, and a stalled receiver holds the block only once a second result is
// ready.
// After reset the table is cleared entry by entry over all RULE_DEPTH entries,
// while s_axis_tready stays low; APB writes are taken at any time.
// active_rules is written through the APB port at byte address 0.
module ipv4_acl_whitelist_match #(
  parameter int unsigned RULE_DEPTH = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Fields from bit 0: rule_slot, rule_flag_bits, rule_src_network,
  // rule_src_mask, rule_dest_addr, rule_port_low, rule_port_high,
  // proto_number, source_addr, dest_addr, dest_port, zero pad.
  input  logic [acl_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // Fields from bit 0: action.
  input  logic [acl_pkg::ACTION_W-1:0]      s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0: rule_hit, port_result, port_replaced, drop_item, zero pad.
  output logic [acl_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int unsigned AW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RULE_DEPTH + 1);

  logic [7:0]         active_rules_q;
  logic               reg_sel;
  acl_pkg::acl_cmd_t  cmd;
  acl_pkg::acl_stat_t stat;
  logic [CW-1:0]      idx;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign prdata  = reg_sel ? {24'd0, active_rules_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_rules_q <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      active_rules_q <= pwdata[7:0];
    end
  end

  acl_ctrl #(
    .RULE_DEPTH (RULE_DEPTH),
    .CW         (CW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .active_rules_i (active_rules_q),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .idx_o          (idx)
  );

  acl_dpath #(
    .RULE_DEPTH (RULE_DEPTH),
    .AW         (AW),
    .CW         (CW)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_action_i (s_axis_tuser),
    .cmd_i       (cmd),
    .idx_i       (idx),
    .stat_o      (stat),
    .out_data_o  (m_axis_tdata)
  );

endmodule
